@@ design/cas_pkg.sv @@
// Package for the corner autotile selector: field widths, codes, the item
// record passed from the control unit to the window stage, and the corner rule.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cas_pkg;

   localparam int DIM_W      = 9;
   localparam int ROW_W      = 9;
   localparam int COORD_W    = 8;
   localparam int SPRITE_W   = 4;
   localparam int BIOME_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int LINE_W     = 2 * BIOME_W;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = CSR_IDX_W'(1);

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // top left
   localparam logic [SPRITE_W-1:0] SPR_TL_NONE = 4'd2;
   localparam logic [SPRITE_W-1:0] SPR_TL_ALL  = 4'd8;
   localparam logic [SPRITE_W-1:0] SPR_TL_BOTH = 4'd0;
   localparam logic [SPRITE_W-1:0] SPR_TL_A    = 4'd10;
   localparam logic [SPRITE_W-1:0] SPR_TL_B    = 4'd11;
   // top right
   localparam logic [SPRITE_W-1:0] SPR_TR_NONE = 4'd3;
   localparam logic [SPRITE_W-1:0] SPR_TR_ALL  = 4'd9;
   localparam logic [SPRITE_W-1:0] SPR_TR_BOTH = 4'd1;
   localparam logic [SPRITE_W-1:0] SPR_TR_A    = 4'd15;
   localparam logic [SPRITE_W-1:0] SPR_TR_B    = 4'd11;
   // bottom left
   localparam logic [SPRITE_W-1:0] SPR_BL_NONE = 4'd6;
   localparam logic [SPRITE_W-1:0] SPR_BL_ALL  = 4'd12;
   localparam logic [SPRITE_W-1:0] SPR_BL_BOTH = 4'd4;
   localparam logic [SPRITE_W-1:0] SPR_BL_A    = 4'd14;
   localparam logic [SPRITE_W-1:0] SPR_BL_B    = 4'd10;
   // bottom right
   localparam logic [SPRITE_W-1:0] SPR_BR_NONE = 4'd7;
   localparam logic [SPRITE_W-1:0] SPR_BR_ALL  = 4'd13;
   localparam logic [SPRITE_W-1:0] SPR_BR_BOTH = 4'd5;
   localparam logic [SPRITE_W-1:0] SPR_BR_A    = 4'd14;
   localparam logic [SPRITE_W-1:0] SPR_BR_B    = 4'd15;

   typedef logic [BIOME_W-1:0]  biome_type;
   typedef logic [SPRITE_W-1:0] sprite_type;

   typedef struct packed {
      biome_type          biome;
      logic               res;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               lo;
      logic               ro;
      logic               uo;
      logic               dok;
      logic               last;
   } item_type;

   // ea, eb: the two side neighbours; ed: the diagonal one
   function automatic sprite_type corner_pick(
      input logic       ea,
      input logic       eb,
      input logic       ed,
      input sprite_type v_none,
      input sprite_type v_all,
      input sprite_type v_both,
      input sprite_type v_a,
      input sprite_type v_b
   );
      sprite_type v;
      if (!ea && !eb && !ed) begin
         v = v_none;
      end else if (ea && eb && ed) begin
         v = v_all;
      end else if (ea && eb) begin
         v = v_both;
      end else if (!ea && !eb) begin
         v = v_none;
      end else if (ea) begin
         v = v_a;
      end else begin
         v = v_b;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

@@ design/cas_line_mem.sv @@
// Line buffer memory: both buffered rows of one column in one word, one read
// and one write port, registered read with a bypass for a same-column write.
// Uses cas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cas_line_mem
   import cas_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [LINE_W-1:0] wr_data,
   output logic      [LINE_W-1:0] rd_data
);

   logic [LINE_W-1:0] line_mem [DEPTH];
   logic [LINE_W-1:0] rd_q_ff;
   logic [LINE_W-1:0] byp_data_ff, byp_data_in;
   logic              byp_ff, byp_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= line_mem[rd_addr];
      end
   end

   // hold the bypass until the next read
   always_comb begin
      byp_in      = byp_ff;
      byp_data_in = byp_data_ff;
      if (rd_en) begin
         byp_in      = wr_en && (wr_addr == rd_addr);
         byp_data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
      byp_data_ff <= byp_data_in;
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_q_ff;

endmodule

`default_nettype wire

@@ design/cas_ctrl.sv @@
// Control unit: map size registers, input and output raster counters, and the
// classification of each transfer into an item record and a line buffer column.
// Uses cas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cas_ctrl
   import cas_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int AW         = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  req_accept,
   input  wire logic                  req_operation,
   input  wire biome_type             req_biome,
   output logic                       push,
   output item_type                   item,
   output logic      [AW-1:0]         rd_addr
);

   localparam int DIM_MAX = (1 << DIM_W) - 1;
   localparam int WCAP    = (MAX_WIDTH  > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
   localparam int HCAP    = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
   localparam int CMPW    = ((AW > DIM_W) ? AW : DIM_W) + 1;
   localparam int RW1     = ROW_W + 1;

   logic [DIM_W-1:0] map_width_ff, map_width_in;
   logic [DIM_W-1:0] map_height_ff, map_height_in;
   logic [AW-1:0]    in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [AW-1:0]    out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   logic [DIM_W-1:0] w, h;
   logic             in_col_last, out_col_last, out_row_last;
   logic             map_done, has_res, last, csr_hit;

   always_comb begin
      if (map_width_ff == '0) begin
         w = DIM_W'(1);
      end else if (map_width_ff > DIM_W'(WCAP)) begin
         w = DIM_W'(WCAP);
      end else begin
         w = map_width_ff;
      end
      if (map_height_ff == '0) begin
         h = DIM_W'(1);
      end else if (map_height_ff > DIM_W'(HCAP)) begin
         h = DIM_W'(HCAP);
      end else begin
         h = map_height_ff;
      end
   end

   always_comb begin
      in_col_last  = (CMPW'(in_col_ff)  + CMPW'(1)) >= CMPW'(w);
      out_col_last = (CMPW'(out_col_ff) + CMPW'(1)) >= CMPW'(w);
      out_row_last = (RW1'(out_row_ff)  + RW1'(1))  >= RW1'(h);
      map_done     = in_row_ff >= ROW_W'(h);
      has_res      = (in_row_ff >= ROW_W'(2)) ||
                     ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
      last         = out_col_last && out_row_last;
      push         = req_accept && !((req_operation == OP_DRAIN) && !map_done);
      csr_hit      = csr_write_en &&
                     ((csr_index == CSR_MAP_WIDTH) || (csr_index == CSR_MAP_HEIGHT));
   end

   always_comb begin
      item.biome = map_done ? '0 : req_biome;
      item.res   = has_res;
      item.x     = COORD_W'(out_col_ff);
      item.y     = COORD_W'(out_row_ff);
      item.lo    = out_col_ff != '0;
      item.ro    = !out_col_last;
      item.uo    = out_row_ff != '0;
      item.dok   = !out_row_last;
      item.last  = last;
      rd_addr    = in_col_ff;
   end

   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      if (csr_hit) begin
         if (csr_index == CSR_MAP_WIDTH) begin
            map_width_in = csr_data;
         end else begin
            map_height_in = csr_data;
         end
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (push) begin
         if (in_col_last) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + AW'(1);
         end
         if (has_res) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= DIM_RESET;
         map_height_ff <= DIM_RESET;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
      end
   end

endmodule

`default_nettype wire

@@ design/cas_window.sv @@
// Window stage: takes the line buffer word of an item, writes the column back,
// shifts the 3x3 window, applies the corner rules and holds the result register.
// Uses cas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cas_window
   import cas_pkg::*;
#(
   parameter int AW = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire item_type          item,
   input  wire logic [AW-1:0]     addr,
   input  wire logic [LINE_W-1:0] rd_data,
   output logic                   busy,
   output logic                   wr_en,
   output logic      [AW-1:0]     wr_addr,
   output logic      [LINE_W-1:0] wr_data,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output logic      [COORD_W-1:0] rsp_tile_x,
   output logic      [COORD_W-1:0] rsp_tile_y,
   output sprite_type             rsp_corner_top_left,
   output sprite_type             rsp_corner_top_right,
   output sprite_type             rsp_corner_bottom_left,
   output sprite_type             rsp_corner_bottom_right,
   output logic                   rsp_last_of_frame
);

   logic        stg_vld_ff, stg_vld_in;
   item_type    stg_item_ff;
   logic [AW-1:0] stg_addr_ff;
   biome_type   win_ff [9];
   biome_type   win_in [9];
   logic        go;
   biome_type   up, mid;
   logic [8:0]  in_map, eq;

   logic        out_vld_ff, out_vld_in;
   logic [COORD_W-1:0] out_x_ff, out_y_ff;
   sprite_type  out_tl_ff, out_tr_ff, out_bl_ff, out_br_ff;
   sprite_type  tl_in, tr_in, bl_in, br_in;
   logic        out_last_ff;

   always_comb begin
      go         = stg_vld_ff && (!stg_item_ff.res || !out_vld_ff || !rsp_stall);
      busy       = stg_vld_ff && !go;
      stg_vld_in = push ? 1'b1 : (go ? 1'b0 : stg_vld_ff);
      up         = rd_data[LINE_W-1:BIOME_W];
      mid        = rd_data[BIOME_W-1:0];
      wr_en      = go;
      wr_addr    = stg_addr_ff;
      wr_data    = {mid, stg_item_ff.biome};
   end

   // shift left by one column, new column on the right
   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = up;
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = mid;
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = stg_item_ff.biome;
   end

   always_comb begin
      in_map[0] = stg_item_ff.uo && stg_item_ff.lo;
      in_map[1] = stg_item_ff.uo;
      in_map[2] = stg_item_ff.uo && stg_item_ff.ro;
      in_map[3] = stg_item_ff.lo;
      in_map[4] = 1'b1;
      in_map[5] = stg_item_ff.ro;
      in_map[6] = stg_item_ff.dok && stg_item_ff.lo;
      in_map[7] = stg_item_ff.dok;
      in_map[8] = stg_item_ff.dok && stg_item_ff.ro;
      for (int i = 0; i < 9; i++) begin
         eq[i] = !in_map[i] || (win_in[i] == win_in[4]);
      end
      tl_in = corner_pick(eq[1], eq[3], eq[0], SPR_TL_NONE, SPR_TL_ALL, SPR_TL_BOTH,
                          SPR_TL_A, SPR_TL_B);
      tr_in = corner_pick(eq[1], eq[5], eq[2], SPR_TR_NONE, SPR_TR_ALL, SPR_TR_BOTH,
                          SPR_TR_A, SPR_TR_B);
      bl_in = corner_pick(eq[3], eq[7], eq[6], SPR_BL_NONE, SPR_BL_ALL, SPR_BL_BOTH,
                          SPR_BL_A, SPR_BL_B);
      br_in = corner_pick(eq[5], eq[7], eq[8], SPR_BR_NONE, SPR_BR_ALL, SPR_BR_BOTH,
                          SPR_BR_A, SPR_BR_B);
   end

   always_comb begin
      if (go && stg_item_ff.res) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         stg_vld_ff <= stg_vld_in;
         out_vld_ff <= out_vld_in;
         if (go) begin
            for (int i = 0; i < 9; i++) begin
               win_ff[i] <= win_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stg_item_ff <= item;
         stg_addr_ff <= addr;
      end
      if (go && stg_item_ff.res) begin
         out_x_ff    <= stg_item_ff.x;
         out_y_ff    <= stg_item_ff.y;
         out_tl_ff   <= tl_in;
         out_tr_ff   <= tr_in;
         out_bl_ff   <= bl_in;
         out_br_ff   <= br_in;
         out_last_ff <= stg_item_ff.last;
      end
   end

   assign rsp_valid               = out_vld_ff;
   assign rsp_tile_x              = out_x_ff;
   assign rsp_tile_y              = out_y_ff;
   assign rsp_corner_top_left     = out_tl_ff;
   assign rsp_corner_top_right    = out_tr_ff;
   assign rsp_corner_bottom_left  = out_bl_ff;
   assign rsp_corner_bottom_right = out_br_ff;
   assign rsp_last_of_frame       = out_last_ff;

endmodule

`default_nettype wire

@@ design/corner_autotile_selector_core.sv @@
// Corner autotile selector. One transfer per cycle in and out while rsp_stall is low; a
// result passes the staging and result registers after the transfer that completes its
// neighbourhood, which is the item one row and one tile later in raster order. The line
// buffer word is read in the transfer cycle, written back as the staging register
// advances; a same-column read in the write cycle takes the bypass. Reset sets both map
// dimensions to 64, clears counters, window and result valid; the memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module corner_autotile_selector_core
   import cas_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_operation,
   input  wire logic [BIOME_W-1:0]    req_biome,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [COORD_W-1:0]    rsp_tile_x,
   output logic      [COORD_W-1:0]    rsp_tile_y,
   output logic      [SPRITE_W-1:0]   rsp_corner_top_left,
   output logic      [SPRITE_W-1:0]   rsp_corner_top_right,
   output logic      [SPRITE_W-1:0]   rsp_corner_bottom_left,
   output logic      [SPRITE_W-1:0]   rsp_corner_bottom_right,
   output logic                       rsp_last_of_frame
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic              req_accept, push, busy;
   item_type          item;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic              wr_en;
   logic [LINE_W-1:0] wr_data, rd_data;

   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;

   cas_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .AW         (AW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_accept    (req_accept),
      .req_operation (req_operation),
      .req_biome     (req_biome),
      .push          (push),
      .item          (item),
      .rd_addr       (rd_addr)
   );

   cas_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (push),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   cas_window #(
      .AW (AW)
   ) u_window (
      .clock                   (clock),
      .reset                   (reset),
      .push                    (push),
      .item                    (item),
      .addr                    (rd_addr),
      .rd_data                 (rd_data),
      .busy                    (busy),
      .wr_en                   (wr_en),
      .wr_addr                 (wr_addr),
      .wr_data                 (wr_data),
      .rsp_stall               (rsp_stall),
      .rsp_valid               (rsp_valid),
      .rsp_tile_x              (rsp_tile_x),
      .rsp_tile_y              (rsp_tile_y),
      .rsp_corner_top_left     (rsp_corner_top_left),
      .rsp_corner_top_right    (rsp_corner_top_right),
      .rsp_corner_bottom_left  (rsp_corner_bottom_left),
      .rsp_corner_bottom_right (rsp_corner_bottom_right),
      .rsp_last_of_frame       (rsp_last_of_frame)
   );

   ap_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   ap_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   ap_wr_once: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !push) |=> !wr_en)
      else $error("line buffer written twice for one transfer");

endmodule

`default_nettype wire
